/* rtl/triangle_geometry_metrics_defines.svh */
// Assertion macros shared by the triangle metrics RTL.
// Included by the top level; no other dependencies.
`ifndef TRIANGLE_GEOMETRY_METRICS_DEFINES_SVH
`define TRIANGLE_GEOMETRY_METRICS_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define TGM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define TGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tgm_pkg.sv */
// Shared widths and helpers for the triangle metrics pipeline.
// No dependencies.
`timescale 1ns / 1ps
package tgm_pkg;
    localparam int COORD_BITS = 24;
    localparam int NORM_BITS  = COORD_BITS + 1;
    localparam int LEN_BITS   = 25;
    localparam int AREA_BITS  = 48;
    localparam int SQ_BITS    = 2 * NORM_BITS;
    localparam int RAD_BITS   = SQ_BITS + 1;
    localparam int ROOT_BITS  = (RAD_BITS + 1) / 2;
    localparam int RAD_PAD    = 2 * ROOT_BITS;
    localparam int SREM_BITS  = ROOT_BITS + 3;
    localparam int CROSS_BITS = SQ_BITS + 1;
    localparam int MAG_BITS   = SQ_BITS;
    localparam int QUO_BITS   = 26;
    localparam int DREM_BITS  = ROOT_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [NORM_BITS-1:0]  t_norm;

    function automatic t_norm coord_diff(input t_coord a, input t_coord b);
        coord_diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    endfunction
endpackage

/* rtl/tgm_if.sv */
// Request and result channels of the triangle metrics block.
// Depends on tgm_pkg.
`timescale 1ns / 1ps
interface tgm_in_if import tgm_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord vertex0_x;
    t_coord vertex0_y;
    t_coord vertex1_x;
    t_coord vertex1_y;
    t_coord vertex2_x;
    t_coord vertex2_y;
    modport source (output valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
                    vertex2_x, vertex2_y, input ready);
    modport sink (input valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
                  vertex2_x, vertex2_y, output ready);
endinterface

interface tgm_out_if import tgm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_norm                normal0_x;
    t_norm                normal0_y;
    t_norm                normal1_x;
    t_norm                normal1_y;
    t_norm                normal2_x;
    t_norm                normal2_y;
    logic [LEN_BITS-1:0]  edge0_length;
    logic [LEN_BITS-1:0]  edge1_length;
    logic [LEN_BITS-1:0]  edge2_length;
    logic [AREA_BITS-1:0] tri_area;
    logic [LEN_BITS-1:0]  min_height;
    logic                 degenerate;
    modport source (output valid, normal0_x, normal0_y, normal1_x, normal1_y, normal2_x,
                    normal2_y, edge0_length, edge1_length, edge2_length, tri_area,
                    min_height, degenerate, input ready);
    modport sink (input valid, normal0_x, normal0_y, normal1_x, normal1_y, normal2_x,
                  normal2_y, edge0_length, edge1_length, edge2_length, tri_area,
                  min_height, degenerate, output ready);
endinterface

/* rtl/triangle_geometry_metrics.sv */
// Channel   Dir  Payload
// i_tri     in   three vertices, signed Q7.16
// o_res     out  normals, edge lengths, area, min height, degenerate flag
//
// One triangle enters per cycle while the result is not stalled. The pipeline has
// 3 front stages, 26 square-root stages, 1 max stage, 26 divider stages and an
// output register. Depth is set by one root bit and one quotient bit per stage.
// Reset is synchronous, active low, and clears the valid bits only.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Depends on tgm_pkg, tgm_if, tgm_isqrt_pipe, tgm_div_pipe and the defines header.
`timescale 1ns / 1ps
`include "triangle_geometry_metrics_defines.svh"
module triangle_geometry_metrics import tgm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tgm_in_if.sink   i_tri,
    tgm_out_if.source o_res
);
    typedef struct packed {
        t_norm [5:0]         n;
        logic [MAG_BITS-1:0] mag;
        logic                degen;
    } t_side;

    typedef struct packed {
        t_side                     s;
        logic [2:0][ROOT_BITS-1:0] len;
    } t_side2;

    logic en;
    assign en = !o_res.valid || o_res.ready;
    assign i_tri.ready = en;

    // front stages
    logic                     r_v1, r_v2, r_v3;
    t_norm                    r1_n [6];
    t_norm                    r2_n [6];
    logic [SQ_BITS-1:0]       r2_sq [6];
    logic signed [SQ_BITS-1:0] r2_p0, r2_p1;
    logic [RAD_BITS-1:0]      r3_rad [3];
    t_side                    r3_s;
    logic signed [CROSS_BITS-1:0] shoelace;
    logic signed [SQ_BITS-1:0] prod [6];

    assign shoelace = {r2_p0[SQ_BITS-1], r2_p0} - {r2_p1[SQ_BITS-1], r2_p1};

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            prod[i] = r1_n[i] * r1_n[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_n[0] <= coord_diff(i_tri.vertex2_y, i_tri.vertex1_y);
            r1_n[1] <= coord_diff(i_tri.vertex1_x, i_tri.vertex2_x);
            r1_n[2] <= coord_diff(i_tri.vertex0_y, i_tri.vertex2_y);
            r1_n[3] <= coord_diff(i_tri.vertex2_x, i_tri.vertex0_x);
            r1_n[4] <= coord_diff(i_tri.vertex1_y, i_tri.vertex0_y);
            r1_n[5] <= coord_diff(i_tri.vertex0_x, i_tri.vertex1_x);
            for (int i = 0; i < 6; i++) begin
                r2_n[i]  <= r1_n[i];
                r2_sq[i] <= SQ_BITS'(prod[i]);
            end
            // shoelace sum as n2y*n1x - n1y*n2x
            r2_p0 <= r1_n[5] * r1_n[2];
            r2_p1 <= r1_n[3] * r1_n[4];
            for (int i = 0; i < 3; i++) begin
                r3_rad[i] <= {1'b0, r2_sq[2*i]} + {1'b0, r2_sq[2*i+1]};
                r3_s.n[2*i]   <= r2_n[2*i];
                r3_s.n[2*i+1] <= r2_n[2*i+1];
            end
            r3_s.mag   <= shoelace[CROSS_BITS-1] ? MAG_BITS'(-shoelace)
                                                 : MAG_BITS'(shoelace);
            r3_s.degen <= (shoelace == '0);
        end
    end

    // square roots
    logic [ROOT_BITS-1:0] len [3];
    for (genvar g = 0; g < 3; g++) begin : g_sqrt
        tgm_isqrt_pipe u_sqrt (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rad  (r3_rad[g]),
            .o_root (len[g])
        );
    end

    logic  r_vs [ROOT_BITS];
    t_side r_ss [ROOT_BITS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ss[0] <= r3_s;
            for (int k = 1; k < ROOT_BITS; k++) begin
                r_ss[k] <= r_ss[k-1];
            end
        end
    end

    // longest edge
    logic                 r_v4;
    t_side2               r4_s;
    logic [ROOT_BITS-1:0] r4_max;
    logic [ROOT_BITS-1:0] max01;
    assign max01 = (len[1] > len[0]) ? len[1] : len[0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_s.s      <= r_ss[ROOT_BITS-1];
            r4_s.len[0] <= len[0];
            r4_s.len[1] <= len[1];
            r4_s.len[2] <= len[2];
            r4_max      <= (len[2] > max01) ? len[2] : max01;
        end
    end

    // height divide
    logic [QUO_BITS-1:0] quo;
    tgm_div_pipe u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_dvd (r4_s.s.mag),
        .i_dvs (r4_max),
        .o_quo (quo)
    );

    logic   r_vd [QUO_BITS];
    t_side2 r_sd [QUO_BITS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r4_s;
            for (int k = 1; k < QUO_BITS; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            for (int k = 0; k < ROOT_BITS; k++) r_vs[k] <= 1'b0;
            for (int k = 0; k < QUO_BITS; k++)  r_vd[k] <= 1'b0;
            o_res.valid <= 1'b0;
        end else if (en) begin
            r_v1 <= i_tri.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vs[0] <= r_v3;
            for (int k = 1; k < ROOT_BITS; k++) r_vs[k] <= r_vs[k-1];
            r_v4 <= r_vs[ROOT_BITS-1];
            r_vd[0] <= r_v4;
            for (int k = 1; k < QUO_BITS; k++)  r_vd[k] <= r_vd[k-1];
            o_res.valid <= r_vd[QUO_BITS-1];
        end
    end

    // output register
    t_side2 fin;
    assign fin = r_sd[QUO_BITS-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res.normal0_x    <= fin.s.n[0];
            o_res.normal0_y    <= fin.s.n[1];
            o_res.normal1_x    <= fin.s.n[2];
            o_res.normal1_y    <= fin.s.n[3];
            o_res.normal2_x    <= fin.s.n[4];
            o_res.normal2_y    <= fin.s.n[5];
            o_res.edge0_length <= fin.len[0][LEN_BITS-1:0];
            o_res.edge1_length <= fin.len[1][LEN_BITS-1:0];
            o_res.edge2_length <= fin.len[2][LEN_BITS-1:0];
            o_res.tri_area     <= fin.s.mag[AREA_BITS:1];
            // drop the quotient when the triangle is flat
            o_res.min_height   <= fin.s.degen ? '0 : quo[LEN_BITS-1:0];
            o_res.degenerate   <= fin.s.degen;
        end
    end

    `TGM_ASSERT_NOW(a_flat_zero, i_clk, i_rst_n, o_res.valid && o_res.degenerate, o_res.min_height == '0 && o_res.tri_area == '0, "flat triangle with nonzero height or area")
    `TGM_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_tri.valid && i_tri.ready, r_v1, "accepted request missing from first stage")
    `TGM_ASSERT_NOW(a_max_len, i_clk, i_rst_n, r_v4, r4_max >= r4_s.len[0] && r4_max >= r4_s.len[1] && r4_max >= r4_s.len[2], "longest edge below an edge")
    `TGM_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_res.valid, i_tri.ready, "input stalled with empty output")
endmodule

/* rtl/tgm_isqrt_pipe.sv */
// Pipelined integer square root, one root bit per stage.
// Depends on tgm_pkg.
`timescale 1ns / 1ps
module tgm_isqrt_pipe import tgm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [RAD_BITS-1:0] i_rad,
    output logic [ROOT_BITS-1:0] o_root
);
    logic [RAD_PAD-1:0]   r_rad  [ROOT_BITS];
    logic [SREM_BITS-1:0] r_rem  [ROOT_BITS];
    logic [ROOT_BITS-1:0] r_root [ROOT_BITS];
    logic [RAD_PAD-1:0]   n_rad  [ROOT_BITS];
    logic [SREM_BITS-1:0] n_rem  [ROOT_BITS];
    logic [ROOT_BITS-1:0] n_root [ROOT_BITS];

    always_comb begin
        logic [RAD_PAD-1:0]   s_rad;
        logic [SREM_BITS-1:0] s_rem;
        logic [ROOT_BITS-1:0] s_root;
        logic [SREM_BITS-1:0] sh;
        logic [SREM_BITS-1:0] tr;
        for (int k = 0; k < ROOT_BITS; k++) begin
            if (k == 0) begin
                s_rad  = {1'b0, i_rad};
                s_rem  = '0;
                s_root = '0;
            end else begin
                s_rad  = r_rad[k-1];
                s_rem  = r_rem[k-1];
                s_root = r_root[k-1];
            end
            sh = {s_rem[SREM_BITS-3:0], s_rad[RAD_PAD-1 -: 2]};
            tr = {1'b0, s_root, 2'b01};
            n_rad[k] = {s_rad[RAD_PAD-3:0], 2'b00};
            if (sh >= tr) begin
                n_rem[k]  = sh - tr;
                n_root[k] = {s_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                n_rem[k]  = sh;
                n_root[k] = {s_root[ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ROOT_BITS; k++) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[ROOT_BITS-1];
endmodule

/* rtl/tgm_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tgm_pkg.
`timescale 1ns / 1ps
module tgm_div_pipe import tgm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [MAG_BITS-1:0]  i_dvd,
    input  logic [ROOT_BITS-1:0] i_dvs,
    output logic [QUO_BITS-1:0]  o_quo
);
    logic [QUO_BITS-1:0]  r_low [QUO_BITS];
    logic [DREM_BITS-1:0] r_rem [QUO_BITS];
    logic [ROOT_BITS-1:0] r_dvs [QUO_BITS];
    logic [QUO_BITS-1:0]  r_quo [QUO_BITS];
    logic [QUO_BITS-1:0]  n_low [QUO_BITS];
    logic [DREM_BITS-1:0] n_rem [QUO_BITS];
    logic [QUO_BITS-1:0]  n_quo [QUO_BITS];

    always_comb begin
        logic [QUO_BITS-1:0]  s_low;
        logic [DREM_BITS-1:0] s_rem;
        logic [ROOT_BITS-1:0] s_dvs;
        logic [QUO_BITS-1:0]  s_quo;
        logic [DREM_BITS-1:0] sh;
        for (int k = 0; k < QUO_BITS; k++) begin
            if (k == 0) begin
                s_low = i_dvd[QUO_BITS-1:0];
                s_rem = DREM_BITS'(i_dvd[MAG_BITS-1:QUO_BITS]);
                s_dvs = i_dvs;
                s_quo = '0;
            end else begin
                s_low = r_low[k-1];
                s_rem = r_rem[k-1];
                s_dvs = r_dvs[k-1];
                s_quo = r_quo[k-1];
            end
            sh = {s_rem[DREM_BITS-2:0], s_low[QUO_BITS-1]};
            n_low[k] = {s_low[QUO_BITS-2:0], 1'b0};
            if (sh >= {1'b0, s_dvs}) begin
                n_rem[k] = sh - {1'b0, s_dvs};
                n_quo[k] = {s_quo[QUO_BITS-2:0], 1'b1};
            end else begin
                n_rem[k] = sh;
                n_quo[k] = {s_quo[QUO_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QUO_BITS; k++) begin
                r_low[k] <= n_low[k];
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_dvs[k] <= (k == 0) ? i_dvs : r_dvs[k-1];
            end
        end
    end

    assign o_quo = r_quo[QUO_BITS-1];
endmodule
